>>> rtl/tsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsr_pkg;

    // Field widths
    localparam int COORD_BITS = 12;
    localparam int ROW_W      = 11;
    localparam int COLOR_W    = 8;
    localparam int DIM_W      = 12;
    localparam int DIM_MAX    = 2048;

    // Datapath widths, derived from the coordinate and row widths
    localparam int SPAN_W = (COORD_BITS > ROW_W) ? COORD_BITS : ROW_W;
    localparam int SGN_W  = SPAN_W + 2;
    localparam int MAG_W  = SPAN_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int X_W    = PROD_W + 2;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    // Edge lanes
    localparam int LANES      = 2;
    localparam int LANE_LONG  = 0;
    localparam int LANE_SHORT = 1;

    // Register port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_BIT = 2;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    // Request commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ROW_W-1:0]             row_t;
    typedef logic [COLOR_W-1:0]           color_t;
    typedef logic [DIM_W-1:0]             dim_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_EDGE,
        ST_CLIP,
        ST_EMIT
    } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/tsr_job_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsr_job_if import tsr_pkg::*;;
    logic   valid;
    logic   ready;
    logic   cmd;
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_c_x;
    coord_t vert_c_y;
    color_t fill_color;

    modport source (
        output valid, cmd, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
               fill_color,
        input  ready
    );

    modport sink (
        input  valid, cmd, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
               fill_color,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/tsr_span_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsr_span_if import tsr_pkg::*;;
    logic   valid;
    logic   ready;
    row_t   span_row;
    row_t   span_left;
    row_t   span_right;
    color_t span_color;
    logic   span_visible;
    logic   last_span;

    modport source (
        output valid, span_row, span_left, span_right, span_color, span_visible, last_span,
        input  ready
    );

    modport sink (
        input  valid, span_row, span_left, span_right, span_color, span_visible, last_span,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/triangle_span_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Scanline triangle rasterizer.
// The job channel takes load requests (cmd 0: three vertices and a fill color)
// and step requests (cmd 1). A load sorts the vertices by y, clamps the first
// and last rows to the screen; it produces no span.
// Each step request produces one span on the span channel for the next row,
// clipped to screen_width / screen_height, which are set over the APB port
// (screen_width at 0x0, screen_height at 0x4).
// A step on a loaded triangle runs from acceptance to span valid through
// a setup state, a bit-serial shift-add multiply over the MAG_W multiplier bits
// and a restoring divide over the PROD_W quotient bits, both edges worked
// side by side in two lanes, then the edge, clip and emit states.
// No new request is taken while a step is still being worked.
// A step with no triangle loaded goes straight to emit an empty, invisible last span.
// The span sits in an output register; the next request is taken as soon as
// the span is handed to that register, so a stalled receiver holds only the
// following step, which waits until the register drains.
// Reset clears the sequencer, the output valid and the loaded triangle, and
// sets the screen to 640 by 480.

module triangle_span_rasterizer import tsr_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tsr_job_if.sink                    job,
    tsr_span_if.source                 span,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Row clamp to the visible screen
    function automatic row_t clamp_row(input coord_t y, input dim_t h);
        logic signed [SGN_W-1:0] ye;
        logic signed [SGN_W-1:0] he;
        row_t                    r;
        ye = SGN_W'(y);
        he = $signed(SGN_W'(h));
        if (ye < 0)
        begin
            r = '0;
        end
        else if (ye >= he)
        begin
            r = (h == '0) ? '0 : ROW_W'(h - DIM_W'(1));
        end
        else
        begin
            r = ye[ROW_W-1:0];
        end
        return r;
    endfunction

    function automatic dim_t eff_dim(input dim_t v);
        return (v > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : v;
    endfunction

    // Control registers
    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             active_reg, active_next;
    logic             out_valid_reg, out_valid_next;
    dim_t             width_reg, width_next;
    dim_t             height_reg, height_next;

    // Triangle registers
    coord_t sorted_x_reg [3];
    coord_t sorted_x_next [3];
    coord_t sorted_y_reg [3];
    coord_t sorted_y_next [3];
    color_t color_reg, color_next;
    row_t   row_reg, row_next;
    row_t   final_reg, final_next;

    // Step working registers
    row_t                    y_reg, y_next;
    logic                    last_reg, last_next;
    logic [MAG_W-1:0]        w_mag_reg [LANES];
    logic [MAG_W-1:0]        w_mag_next [LANES];
    logic [MAG_W-1:0]        dy_reg [LANES];
    logic [MAG_W-1:0]        dy_next [LANES];
    logic                    neg_reg [LANES];
    logic                    neg_next [LANES];
    coord_t                  base_reg [LANES];
    coord_t                  base_next [LANES];
    logic [PROD_W-1:0]       prod_reg [LANES];
    logic [PROD_W-1:0]       prod_next [LANES];
    logic [MAG_W-1:0]        rem_reg [LANES];
    logic [MAG_W-1:0]        rem_next [LANES];
    logic signed [X_W-1:0]   x_reg [LANES];
    logic signed [X_W-1:0]   x_next [LANES];

    // Pending and output span
    row_t   pend_row_reg, pend_row_next;
    row_t   pend_left_reg, pend_left_next;
    row_t   pend_right_reg, pend_right_next;
    color_t pend_color_reg, pend_color_next;
    logic   pend_vis_reg, pend_vis_next;
    logic   pend_last_reg, pend_last_next;
    row_t   out_row_reg, out_row_next;
    row_t   out_left_reg, out_left_next;
    row_t   out_right_reg, out_right_next;
    color_t out_color_reg, out_color_next;
    logic   out_vis_reg, out_vis_next;
    logic   out_last_reg, out_last_next;

    // Combinational results
    coord_t                ld_x [3];
    coord_t                ld_y [3];
    row_t                  ld_row;
    row_t                  ld_final;
    logic                  ld_active;
    logic [MAG_W-1:0]      su_t_mag [LANES];
    logic [MAG_W-1:0]      su_w_mag [LANES];
    logic [MAG_W-1:0]      su_dy [LANES];
    logic                  su_neg [LANES];
    coord_t                su_base [LANES];
    logic [PROD_W-1:0]     mul_prod [LANES];
    logic [PROD_W-1:0]     div_prod [LANES];
    logic [MAG_W-1:0]      div_rem [LANES];
    logic signed [X_W-1:0] edge_x [LANES];
    row_t                  cl_left;
    row_t                  cl_right;
    logic                  cl_vis;
    logic                  cfg_wr;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            if (paddr[REG_IDX_BIT] == REG_SCREEN_WIDTH)
            begin
                width_next = pwdata[DIM_W-1:0];
            end
            else
            begin
                height_next = pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[REG_IDX_BIT] == REG_SCREEN_HEIGHT) ?
                    APB_DATA_W'(height_reg) : APB_DATA_W'(width_reg);

    // Sort the incoming vertices by y with three compare-swaps
    always_comb
    begin
        coord_t tx;
        coord_t ty;
        dim_t   h;
        tx = '0;
        ty = '0;
        if (job.vert_a_y < job.vert_b_y)
        begin
            ld_x[0] = job.vert_a_x;
            ld_y[0] = job.vert_a_y;
            ld_x[1] = job.vert_b_x;
            ld_y[1] = job.vert_b_y;
        end
        else
        begin
            ld_x[0] = job.vert_b_x;
            ld_y[0] = job.vert_b_y;
            ld_x[1] = job.vert_a_x;
            ld_y[1] = job.vert_a_y;
        end
        ld_x[2] = job.vert_c_x;
        ld_y[2] = job.vert_c_y;
        if (ld_y[1] > ld_y[2])
        begin
            tx      = ld_x[1];
            ty      = ld_y[1];
            ld_x[1] = ld_x[2];
            ld_y[1] = ld_y[2];
            ld_x[2] = tx;
            ld_y[2] = ty;
        end
        if (ld_y[0] > ld_y[1])
        begin
            tx      = ld_x[0];
            ty      = ld_y[0];
            ld_x[0] = ld_x[1];
            ld_y[0] = ld_y[1];
            ld_x[1] = tx;
            ld_y[1] = ty;
        end
        h         = eff_dim(height_reg);
        ld_row    = clamp_row(ld_y[0], h);
        ld_final  = clamp_row(ld_y[2], h);
        ld_active = ld_y[0] < ld_y[2];
    end

    // Pick each edge's end points and form the magnitudes for the multiply
    always_comb
    begin
        logic signed [SGN_W-1:0] y_ext;
        logic                    upper_half;
        coord_t                  xs [LANES];
        coord_t                  ys [LANES];
        coord_t                  xe [LANES];
        coord_t                  ye [LANES];
        logic signed [SGN_W-1:0] t [LANES];
        logic signed [SGN_W-1:0] d [LANES];
        logic signed [SGN_W-1:0] dyv [LANES];
        y_ext      = $signed(SGN_W'(y_reg));
        upper_half = y_ext < SGN_W'(sorted_y_reg[1]);
        xs[LANE_LONG] = sorted_x_reg[0];
        ys[LANE_LONG] = sorted_y_reg[0];
        xe[LANE_LONG] = sorted_x_reg[2];
        ye[LANE_LONG] = sorted_y_reg[2];
        xs[LANE_SHORT] = upper_half ? sorted_x_reg[0] : sorted_x_reg[1];
        ys[LANE_SHORT] = upper_half ? sorted_y_reg[0] : sorted_y_reg[1];
        xe[LANE_SHORT] = upper_half ? sorted_x_reg[1] : sorted_x_reg[2];
        ye[LANE_SHORT] = upper_half ? sorted_y_reg[1] : sorted_y_reg[2];
        for (int l = 0; l < LANES; l++)
        begin
            t[l]   = y_ext - SGN_W'(ys[l]);
            d[l]   = SGN_W'(xe[l]) - SGN_W'(xs[l]);
            dyv[l] = SGN_W'(ye[l]) - SGN_W'(ys[l]) + SGN_W'(1);
            su_t_mag[l] = t[l][SGN_W-1] ? MAG_W'(-t[l]) : t[l][MAG_W-1:0];
            su_w_mag[l] = d[l][SGN_W-1] ? MAG_W'(SGN_W'(1) - d[l])
                                        : MAG_W'(d[l] + SGN_W'(1));
            su_dy[l]    = dyv[l][MAG_W-1:0];
            su_neg[l]   = t[l][SGN_W-1] ^ d[l][SGN_W-1];
            su_base[l]  = xs[l];
        end
    end

    // One multiplier bit and one quotient bit per cycle in each lane
    always_comb
    begin
        logic [MAG_W:0]   msum [LANES];
        logic [MAG_W-1:0] addend [LANES];
        logic [MAG_W:0]   shifted [LANES];
        logic [MAG_W+1:0] trial [LANES];
        logic             qbit [LANES];
        for (int l = 0; l < LANES; l++)
        begin
            addend[l]   = prod_reg[l][0] ? w_mag_reg[l] : '0;
            msum[l]     = {1'b0, prod_reg[l][PROD_W-1:MAG_W]} + {1'b0, addend[l]};
            mul_prod[l] = {msum[l], prod_reg[l][MAG_W-1:1]};
            shifted[l]  = {rem_reg[l], prod_reg[l][PROD_W-1]};
            trial[l]    = {1'b0, shifted[l]} - {2'b00, dy_reg[l]};
            qbit[l]     = ~trial[l][MAG_W+1];
            div_rem[l]  = qbit[l] ? trial[l][MAG_W-1:0] : shifted[l][MAG_W-1:0];
            div_prod[l] = {prod_reg[l][PROD_W-2:0], qbit[l]};
        end
    end

    // Apply the sign and add the edge's start x
    always_comb
    begin
        logic signed [X_W-1:0] q [LANES];
        for (int l = 0; l < LANES; l++)
        begin
            q[l]      = $signed(X_W'(prod_reg[l]));
            edge_x[l] = X_W'(base_reg[l]) + (neg_reg[l] ? -q[l] : q[l]);
        end
    end

    // Order the long-lane and short-lane edge x values and clip to the screen
    always_comb
    begin
        logic signed [X_W-1:0] lo;
        logic signed [X_W-1:0] hi;
        logic signed [X_W-1:0] wm1;
        dim_t                  h;
        lo  = (x_reg[LANE_LONG] < x_reg[LANE_SHORT]) ? x_reg[LANE_LONG] : x_reg[LANE_SHORT];
        hi  = (x_reg[LANE_LONG] < x_reg[LANE_SHORT]) ? x_reg[LANE_SHORT] : x_reg[LANE_LONG];
        wm1 = $signed(X_W'(eff_dim(width_reg))) - X_W'(1);
        h   = eff_dim(height_reg);
        if (lo < 0)
        begin
            lo = '0;
        end
        if (hi > wm1)
        begin
            hi = wm1;
        end
        cl_vis   = (lo <= hi) && (DIM_W'(y_reg) < h);
        cl_left  = cl_vis ? lo[ROW_W-1:0] : '0;
        cl_right = cl_vis ? hi[ROW_W-1:0] : '0;
    end

    // Sequencer: next state and register updates
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        active_next     = active_reg;
        sorted_x_next   = sorted_x_reg;
        sorted_y_next   = sorted_y_reg;
        color_next      = color_reg;
        row_next        = row_reg;
        final_next      = final_reg;
        y_next          = y_reg;
        last_next       = last_reg;
        w_mag_next      = w_mag_reg;
        dy_next         = dy_reg;
        neg_next        = neg_reg;
        base_next       = base_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        x_next          = x_reg;
        pend_row_next   = pend_row_reg;
        pend_left_next  = pend_left_reg;
        pend_right_next = pend_right_reg;
        pend_color_next = pend_color_reg;
        pend_vis_next   = pend_vis_reg;
        pend_last_next  = pend_last_reg;
        out_row_next    = out_row_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_color_next  = out_color_reg;
        out_vis_next    = out_vis_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg & ~span.ready;
        job.ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                job.ready = 1'b1;
                if (job.valid)
                begin
                    if (job.cmd == CMD_LOAD)
                    begin
                        sorted_x_next = ld_x;
                        sorted_y_next = ld_y;
                        color_next    = job.fill_color;
                        row_next      = ld_row;
                        final_next    = ld_final;
                        active_next   = ld_active;
                    end
                    else if (!active_reg)
                    begin
                        // No triangle: empty final span
                        pend_row_next   = '0;
                        pend_left_next  = '0;
                        pend_right_next = '0;
                        pend_color_next = '0;
                        pend_vis_next   = 1'b0;
                        pend_last_next  = 1'b1;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        // Take this row and advance to the next one unless it is the final row
                        y_next = row_reg;
                        if (row_reg >= final_reg)
                        begin
                            last_next   = 1'b1;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            last_next = 1'b0;
                            row_next  = row_reg + ROW_W'(1);
                        end
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    w_mag_next[l] = su_w_mag[l];
                    dy_next[l]    = su_dy[l];
                    neg_next[l]   = su_neg[l];
                    base_next[l]  = su_base[l];
                    prod_next[l]  = PROD_W'(su_t_mag[l]);
                end
                cnt_next   = '0;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next = mul_prod;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    cnt_next = '0;
                    for (int l = 0; l < LANES; l++)
                    begin
                        rem_next[l] = '0;
                    end
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_DIV:
            begin
                prod_next = div_prod;
                rem_next  = div_rem;
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EDGE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_EDGE:
            begin
                x_next     = edge_x;
                state_next = ST_CLIP;
            end

            ST_CLIP:
            begin
                pend_row_next   = y_reg;
                pend_left_next  = cl_left;
                pend_right_next = cl_right;
                pend_color_next = color_reg;
                pend_vis_next   = cl_vis;
                pend_last_next  = last_reg;
                state_next      = ST_EMIT;
            end

            ST_EMIT:
            begin
                // Hand the span over once the output register is free
                if (!out_valid_reg || span.ready)
                begin
                    out_row_next   = pend_row_reg;
                    out_left_next  = pend_left_reg;
                    out_right_next = pend_right_reg;
                    out_color_next = pend_color_reg;
                    out_vis_next   = pend_vis_reg;
                    out_last_next  = pend_last_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            row_reg       <= '0;
            final_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            row_reg       <= row_next;
            final_reg     <= final_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        sorted_x_reg   <= sorted_x_next;
        sorted_y_reg   <= sorted_y_next;
        color_reg      <= color_next;
        y_reg          <= y_next;
        last_reg       <= last_next;
        w_mag_reg      <= w_mag_next;
        dy_reg         <= dy_next;
        neg_reg        <= neg_next;
        base_reg       <= base_next;
        prod_reg       <= prod_next;
        rem_reg        <= rem_next;
        x_reg          <= x_next;
        pend_row_reg   <= pend_row_next;
        pend_left_reg  <= pend_left_next;
        pend_right_reg <= pend_right_next;
        pend_color_reg <= pend_color_next;
        pend_vis_reg   <= pend_vis_next;
        pend_last_reg  <= pend_last_next;
        out_row_reg    <= out_row_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_color_reg  <= out_color_next;
        out_vis_reg    <= out_vis_next;
        out_last_reg   <= out_last_next;
    end

    // Drive the span channel
    assign span.valid        = out_valid_reg;
    assign span.span_row     = out_row_reg;
    assign span.span_left    = out_left_reg;
    assign span.span_right   = out_right_reg;
    assign span.span_color   = out_color_reg;
    assign span.span_visible = out_vis_reg;
    assign span.last_span    = out_last_reg;

    // Checks
    a_visible_order: assert property (@(posedge clk) disable iff (!rst_n)
        (span.valid && span.span_visible) |-> (span.span_left <= span.span_right))
        else $error("visible span with left beyond right");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (row_reg <= final_reg))
        else $error("current row passed the final row");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && span.valid && !span.ready) |=> (state_reg == ST_EMIT))
        else $error("span handed over while output register was full");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (job.valid && job.ready && job.cmd == CMD_STEP) |=> (state_reg != ST_IDLE))
        else $error("step request left the sequencer idle");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (cnt_reg < CNT_W'(MAG_W)))
        else $error("multiply ran past its bit count");

endmodule

`default_nettype wire
